>>> hw/rtl/line_padding_bit_packer_assert.svh
// ---------------------------------------------------------------------------
// line padding bit packer assertion macros
// shared assertion forms, clocked on clk and muted during rst
// ---------------------------------------------------------------------------
`ifndef LINE_PADDING_BIT_PACKER_ASSERT_SVH
`define LINE_PADDING_BIT_PACKER_ASSERT_SVH

// property that must hold at every edge out of reset
`define LPBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition at one edge implies a condition at the next edge
`define LPBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lpbp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpbp_pkg
// types and constants shared by the line padding bit packer modules
// ---------------------------------------------------------------------------
package lpbp_pkg;

  // register map indexes
  localparam logic REG_LINE_BYTES = 1'b0;
  localparam logic REG_VALID_BITS = 1'b1;

  localparam logic [7:0]  LINE_BYTES_RST = 8'd5;
  localparam logic [10:0] VALID_BITS_RST = 11'd36;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [7:0]  line_bytes;
    logic [10:0] valid_bits;
  } cfg_t;

  // one classified item: kept bits (masked), how many, frame end
  typedef struct packed {
    logic [7:0] bits;
    logic [3:0] take;
    logic       last;
  } entry_t;

endpackage

>>> hw/rtl/lpbp_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpbp_queue
// small register fifo between the classifier and the packer
// ---------------------------------------------------------------------------
module lpbp_queue
  import lpbp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] cnt;
  logic          push;
  logic          pop;

  assign push_ready = (cnt != CW'(DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

>>> hw/rtl/lpbp_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpbp_front
// tracks the byte position in the line and works out the kept bits of each item
// ---------------------------------------------------------------------------
module lpbp_front
  import lpbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       frame_end,
  output logic       q_valid,
  input  logic       q_ready,
  output entry_t     q_entry
);

  logic [7:0]  byte_in_line;
  logic [7:0]  byte_in_line_next;
  logic [11:0] line_bits;
  logic [11:0] keep;
  logic [11:0] done_bits;
  logic [11:0] left;
  logic [3:0]  take;
  logic        accept;

  // zero line length counts as 256 bytes
  assign line_bits = (cfg.line_bytes == 8'd0) ? 12'd2048 : {1'b0, cfg.line_bytes, 3'b000};
  assign keep      = ({1'b0, cfg.valid_bits} > line_bits) ? line_bits
                                                          : {1'b0, cfg.valid_bits};
  assign done_bits = {1'b0, byte_in_line, 3'b000};
  assign left      = keep - done_bits;

  always_comb begin
    if (keep <= done_bits) begin
      take = 4'd0;
    end else if (left > 12'd8) begin
      take = 4'd8;
    end else begin
      take = left[3:0];
    end
  end

  assign q_valid       = in_valid;
  assign in_ready      = q_ready;
  assign q_entry.bits  = in_byte & ~(8'hFF << take);
  assign q_entry.take  = take;
  assign q_entry.last  = frame_end;
  assign accept        = in_valid && q_ready;

  always_comb begin
    byte_in_line_next = byte_in_line + 8'd1;
    if (byte_in_line_next == cfg.line_bytes || frame_end) begin
      byte_in_line_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_line <= 8'd0;
    end else if (accept) begin
      byte_in_line <= byte_in_line_next;
    end
  end

endmodule

>>> hw/rtl/lpbp_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpbp_back
// packs kept bits into bytes and holds up to two results for the output
// ---------------------------------------------------------------------------
`include "line_padding_bit_packer_assert.svh"

module lpbp_back
  import lpbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_ready,
  input  entry_t     q_entry,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [6:0]  acc;
  logic [2:0]  acc_cnt;
  logic [14:0] sum;
  logic [3:0]  tot;
  logic [6:0]  rem_acc;
  logic        emit_a;
  logic        emit_b;
  logic [1:0]  n_res;

  logic [7:0]  ob_byte [2];
  logic        ob_last [2];
  logic [1:0]  ob_cnt;
  logic [7:0]  ob_byte_next [2];
  logic        ob_last_next [2];
  logic [1:0]  ob_cnt_next;
  logic [1:0]  base;
  logic        pop;
  logic        q_pop;

  // merge new bits above the pending ones
  assign sum     = {8'd0, acc} | ({7'd0, q_entry.bits} << acc_cnt);
  assign tot     = {1'b0, acc_cnt} + q_entry.take;
  assign emit_a  = tot[3];
  assign rem_acc = emit_a ? sum[14:8] : sum[6:0];
  assign emit_b  = q_entry.last && (tot[2:0] != 3'd0);
  assign n_res   = {1'b0, emit_a} + {1'b0, emit_b};

  assign out_valid = (ob_cnt != 2'd0);
  assign out_byte  = ob_byte[0];
  assign out_last  = ob_last[0];
  assign pop       = out_valid && out_ready;
  assign base      = ob_cnt - {1'b0, pop};
  assign q_ready   = ({1'b0, base} + {1'b0, n_res}) <= 3'd2;
  assign q_pop     = q_valid && q_ready;

  always_comb begin
    ob_byte_next[0] = pop ? ob_byte[1] : ob_byte[0];
    ob_last_next[0] = pop ? ob_last[1] : ob_last[0];
    ob_byte_next[1] = ob_byte[1];
    ob_last_next[1] = ob_last[1];
    ob_cnt_next     = base;
    if (q_pop) begin
      ob_cnt_next = base + n_res;
      if (emit_a) begin
        ob_byte_next[base[0]] = sum[7:0];
        ob_last_next[base[0]] = q_entry.last && !emit_b;
        if (emit_b) begin
          ob_byte_next[1] = {1'b0, rem_acc};
          ob_last_next[1] = 1'b1;
        end
      end else if (emit_b) begin
        ob_byte_next[base[0]] = {1'b0, rem_acc};
        ob_last_next[base[0]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ob_byte[0] <= ob_byte_next[0];
    ob_byte[1] <= ob_byte_next[1];
    ob_last[0] <= ob_last_next[0];
    ob_last[1] <= ob_last_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_cnt  <= 2'd0;
      acc     <= 7'd0;
      acc_cnt <= 3'd0;
    end else begin
      ob_cnt <= ob_cnt_next;
      if (q_pop) begin
        acc     <= q_entry.last ? 7'd0 : rem_acc;
        acc_cnt <= q_entry.last ? 3'd0 : tot[2:0];
      end
    end
  end

  `LPBP_ASSERT(a_ob_bound, ob_cnt <= 2'd2, "output buffer overfilled")
  `LPBP_ASSERT(a_acc_clean, (acc >> acc_cnt) == 7'd0, "stray bits above pending count")
  `LPBP_ASSERT_NEXT(a_frame_flush, q_pop && q_entry.last, acc_cnt == 3'd0, "no flush at frame end")

endmodule

>>> hw/rtl/line_padding_bit_packer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_padding_bit_packer
// keeps the leading bits of each line and packs them into a byte stream
// ---------------------------------------------------------------------------
// usage
//   s_tdata[7:0] carries one input byte per item, s_tlast marks frame end
//   m_tdata[7:0] carries one packed byte, m_tlast marks the frame's last byte
//   apb port: line_bytes at 0x0, valid_bits at 0x4, pready always high
// timing
//   one item per cycle sustained while m_tready is high; an accepted item
//   is registered in the queue, then in the output buffer, on its way to m_tdata
//   a frame end that flushes a partial byte after a full one gives two
//   result items; the second follows the first out of the output buffer
//   throughput is set by the packer, which retires one queue item per cycle
//   while its two-entry output buffer has room
// reset
//   rst clears line position, pending bits, queue and output buffer, and
//   loads line_bytes = 5, valid_bits = 36
// stall
//   when m_tready is low the output buffer fills, the packer holds, the
//   queue fills and s_tready drops; nothing is lost
// ---------------------------------------------------------------------------
module line_padding_bit_packer
  import lpbp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] in_byte
  input  logic        s_tlast,  // frame_end
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // [7:0] out_byte
  output logic        m_tlast,  // out_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t   cfg;
  logic   cfg_wr;
  logic   reg_sel;
  logic   q_in_valid;
  logic   q_in_ready;
  entry_t q_in_entry;
  logic   q_out_valid;
  logic   q_out_ready;
  entry_t q_out_entry;

  // register select is the word index; low address bits are ignored
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_bytes <= LINE_BYTES_RST;
      cfg.valid_bits <= VALID_BITS_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_LINE_BYTES: cfg.line_bytes <= pwdata[7:0];
        REG_VALID_BITS: cfg.valid_bits <= pwdata[10:0];
        default:        cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LINE_BYTES: prdata = {24'd0, cfg.line_bytes};
      REG_VALID_BITS: prdata = {21'd0, cfg.valid_bits};
      default:        prdata = 32'd0;
    endcase
  end

  // front: line position and kept-bit count per item
  lpbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .frame_end (s_tlast),
    .q_valid   (q_in_valid),
    .q_ready   (q_in_ready),
    .q_entry   (q_in_entry)
  );

  // decouples the classifier from the packer
  lpbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_entry (q_in_entry),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_entry  (q_out_entry)
  );

  // back: bit accumulation, byte emission and frame flush
  lpbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_out_valid),
    .q_ready   (q_out_ready),
    .q_entry   (q_out_entry),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
